FILE: hdl/sobel_edge_magnitude_3x3_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel edge magnitude block
// Each macro expects signals named clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH

// Consequent in the same cycle as the antecedent
`define SEM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent in the cycle after the antecedent
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sem_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned RGB_W    = 3 * PIX_W;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned GRAD_W   = 11;
  localparam int unsigned SUMSQ_W  = 21;
  localparam int unsigned ROOT_STEPS_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } sem_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GRAD,
    ST_SQR,
    ST_START,
    ST_ROOT,
    ST_HOLD
  } sem_state_t;

  // Enables for the two register stages of a kernel lane
  typedef struct packed {
    logic grad_en;
    logic sq_en;
  } sem_kctl_t;

endpackage

FILE: hdl/sem_if.sv
// ----------------------------------------------------------------------------
// sem_in_if / sem_out_if
// Valid/ready channels for pixel beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, operation, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, operation, in_red, in_green, in_blue, output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last_of_frame;

  modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

FILE: hdl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sem_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/sem_kernel.sv
// ----------------------------------------------------------------------------
// sem_kernel
// One colour lane: Sobel gradients, then the sum of their squares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sem_kernel (
  input  logic                          clk,
  input  sem_pkg::sem_kctl_t            ctl,
  input  logic [8:0][sem_pkg::PIX_W-1:0] px,
  output logic [sem_pkg::SUMSQ_W-1:0]   sumsq
);
  import sem_pkg::*;

  logic signed [GRAD_W-1:0]  gx_r, gy_r, gx_nxt, gy_nxt;
  logic signed [2*GRAD_W-1:0] sqx, sqy;
  logic [SUMSQ_W-1:0]        sumsq_r, sumsq_nxt;

  // Apply both kernels; window index is row * 3 + column
  always_comb begin
    gx_nxt = $signed({3'b0, px[2]}) + $signed({2'b0, px[5], 1'b0}) + $signed({3'b0, px[8]})
           - $signed({3'b0, px[0]}) - $signed({2'b0, px[3], 1'b0}) - $signed({3'b0, px[6]});
    gy_nxt = $signed({3'b0, px[6]}) + $signed({2'b0, px[7], 1'b0}) + $signed({3'b0, px[8]})
           - $signed({3'b0, px[0]}) - $signed({2'b0, px[1], 1'b0}) - $signed({3'b0, px[2]});
  end

  // Square and add
  always_comb begin
    sqx       = gx_r * gx_r;
    sqy       = gy_r * gy_r;
    sumsq_nxt = SUMSQ_W'(sqx) + SUMSQ_W'(sqy);
  end

  always_ff @(posedge clk) begin
    if (ctl.grad_en) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
    if (ctl.sq_en) begin
      sumsq_r <= sumsq_nxt;
    end
  end

  assign sumsq = sumsq_r;

endmodule

FILE: hdl/sem_root.sv
// ----------------------------------------------------------------------------
// sem_root
// Rounded square root of three lanes, one result bit per cycle, clamped
// to 255: largest n with n*(n-1) below the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sem_root (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [2:0][sem_pkg::SUMSQ_W-1:0]  sumsq,
  output logic [2:0][sem_pkg::PIX_W-1:0]    mag,
  output logic                              done
);
  import sem_pkg::*;

  logic [2:0][SUMSQ_W-1:0] s_r;
  logic [2:0][PIX_W-1:0]   n_r, n_nxt;
  logic [ROOT_STEPS_W-1:0] bit_r;
  logic                    busy_r, done_r;
  logic [2:0][PIX_W-1:0]   cand;
  logic [2:0][2*PIX_W-1:0] prod;

  // Trial bit for each lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i]  = n_r[i] | (PIX_W'(1) << bit_r);
      prod[i]  = cand[i] * (cand[i] - PIX_W'(1));
      n_nxt[i] = (SUMSQ_W'(prod[i]) < s_r[i]) ? cand[i] : n_r[i];
    end
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (bit_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (bit_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Lane data
  always_ff @(posedge clk) begin
    if (start) begin
      s_r   <= sumsq;
      n_r   <= '0;
      bit_r <= '1;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      bit_r <= bit_r - ROOT_STEPS_W'(1);
    end
  end

  assign mag  = n_r;
  assign done = done_r;

endmodule

FILE: hdl/sobel_edge_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3
// 3x3 Sobel edge magnitude on an RGB raster stream, two line RAMs.
//
//   channel   dir  carries
//   in_bus    in   operation, in_red, in_green, in_blue
//   out_bus   out  out_red, out_green, out_blue, last_of_frame
//   cfg_*     in   frame_width (index 0), frame_height (index 1)
//
// One item at a time. An ignored drain only passes idle; an item with no
// result reads the line RAMs in idle and writes back in load; one with a
// result goes on via grad, sqr, start, root (bit-serial sqrt) and hold.
// Reset is synchronous; the line RAMs are not cleared, as their unwritten
// entries only reach masked window positions.
// A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sobel_edge_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sem_in_if.sink                        in_bus,
  sem_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_wdata
);
  import sem_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  sem_state_t state_r, state_nxt;

  logic [WIDTH_W-1:0]  cfg_width_r;
  logic [HEIGHT_W-1:0] cfg_height_r;
  logic [CW-1:0]       eff_w;
  logic [RW-1:0]       eff_h;

  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [2:0][2:0][RGB_W-1:0] win_r;
  logic [RGB_W-1:0] pix_r;
  logic             emit_r;

  logic [RGB_W-1:0] up_rdata, mid_rdata;
  logic             accept, drain_slot, ignore, emit_now, last_now, can_load;
  logic             ram_re, ram_we, root_start, root_done;
  sem_kctl_t        kctl;

  logic [2:0] rok, cok;
  logic [2:0][8:0][PIX_W-1:0] lane_px;
  logic [2:0][SUMSQ_W-1:0]    lane_sq;
  logic [2:0][PIX_W-1:0]      mag;

  logic             out_valid_r;
  logic [2:0][PIX_W-1:0] out_mag_r;
  logic             out_last_r;

  // Effective frame size, clamped to the supported range
  always_comb begin
    if (cfg_width_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      eff_h = RW'(1);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(cfg_height_r);
    end
  end

  assign accept     = in_bus.valid && in_bus.ready;
  assign drain_slot = 32'(in_row_r) >= 32'(eff_h);
  assign ignore     = in_bus.operation && !drain_slot;
  assign emit_now   = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign last_now   = (32'(out_row_r) + 32'd1 >= 32'(eff_h))
                   && (32'(out_col_r) + 32'd1 >= 32'(eff_w));
  assign can_load   = !out_valid_r || out_bus.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && !ignore) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = emit_r ? ST_GRAD : ST_IDLE;
      ST_GRAD:  state_nxt = ST_SQR;
      ST_SQR:   state_nxt = ST_START;
      ST_START: state_nxt = ST_ROOT;
      ST_ROOT:  if (root_done) state_nxt = ST_HOLD;
      ST_HOLD:  if (can_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_bus.ready = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    kctl         = '0;
    root_start   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        ram_re       = 1'b1;
      end
      ST_LOAD:  ram_we       = 1'b1;
      ST_GRAD:  kctl.grad_en = 1'b1;
      ST_SQR:   kctl.sq_en   = 1'b1;
      ST_START: root_start   = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Line RAMs: read at the column while idle, write back in the load state after an accept
  sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(ram_we), .waddr(in_col_r[AW-1:0]), .wdata(mid_rdata),
    .re(ram_re), .raddr(in_col_r[AW-1:0]), .rdata(up_rdata)
  );
  sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(ram_we), .waddr(in_col_r[AW-1:0]), .wdata(pix_r),
    .re(ram_re), .raddr(in_col_r[AW-1:0]), .rdata(mid_rdata)
  );

  // Capture the beat's pixel; drain slots carry zero
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= drain_slot ? '0 : {in_bus.in_blue, in_bus.in_green, in_bus.in_red};
      emit_r <= emit_now;
    end
  end

  // Config, counters and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_W'(640);
      cfg_height_r <= HEIGHT_W'(480);
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      win_r        <= '0;
    end else if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        cfg_width_r <= cfg_wdata[WIDTH_W-1:0];
      end else begin
        cfg_height_r <= cfg_wdata[HEIGHT_W-1:0];
      end
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      win_r     <= '0;
    end else if (state_r == ST_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= up_rdata;
      win_r[1][2] <= mid_rdata;
      win_r[2][2] <= pix_r;
      if (32'(in_col_r) + 32'd1 >= 32'(eff_w)) begin
        in_col_r <= '0;
        in_row_r <= in_row_r + RW'(1);
      end else begin
        in_col_r <= in_col_r + CW'(1);
      end
    end else if (state_r == ST_HOLD && can_load) begin
      if (last_now) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        win_r     <= '0;
      end else if (32'(out_col_r) + 32'd1 >= 32'(eff_w)) begin
        out_col_r <= '0;
        out_row_r <= out_row_r + RW'(1);
      end else begin
        out_col_r <= out_col_r + CW'(1);
      end
    end
  end

  // Mask window positions outside the frame
  always_comb begin
    rok[0] = out_row_r != '0;
    rok[1] = 32'(out_row_r) < 32'(eff_h);
    rok[2] = 32'(out_row_r) + 32'd1 < 32'(eff_h);
    cok[0] = out_col_r != '0;
    cok[1] = 32'(out_col_r) < 32'(eff_w);
    cok[2] = 32'(out_col_r) + 32'd1 < 32'(eff_w);
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          lane_px[c][k*3+l] = (rok[k] && cok[l]) ? win_r[k][l][c*PIX_W +: PIX_W] : '0;
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    sem_kernel u_kernel (
      .clk(clk), .ctl(kctl), .px(lane_px[c]), .sumsq(lane_sq[c])
    );
  end

  sem_root u_root (
    .clk(clk), .rst_n(rst_n), .start(root_start), .sumsq(lane_sq),
    .mag(mag), .done(root_done)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_HOLD && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HOLD && can_load) begin
      out_mag_r  <= mag;
      out_last_r <= last_now;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_red       = out_mag_r[0];
  assign out_bus.out_green     = out_mag_r[1];
  assign out_bus.out_blue      = out_mag_r[2];
  assign out_bus.last_of_frame = out_last_r;

endmodule

FILE: hdl/sem_checker.sv
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks on the Sobel edge magnitude block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_3x3_macros.svh"
module sem_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_operation,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_we
);

  // The block is not ready in the cycle after it takes a pixel beat
  `SEM_ASSERT_NEXT(a_busy_after_pixel, in_valid && in_ready && !in_operation, !in_ready)
  // A new result only appears when the input was not ready the cycle before
  `SEM_ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(!in_ready))
  // Hold a stalled result
  `SEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Config writes only come while no item is in flight
  `SEM_ASSERT_SAME(a_cfg_idle, cfg_we, in_ready)

endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_sem_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_bus.valid), .in_ready(in_bus.ready), .in_operation(in_bus.operation),
  .out_valid(out_bus.valid), .out_ready(out_bus.ready), .cfg_we(cfg_we)
);

FILE: dv/sem_tb_if.sv
// ----------------------------------------------------------------------------
// sem_tb_if
// Testbench side of the pixel and result channels: the interfaces come
// with the RTL, so this file only gathers the beat types used by tb.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sem_tb_pkg;

  typedef struct packed {
    logic       drain;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_beat_t;

endpackage

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and checking for the Sobel edge magnitude block. Pixel beats with
// random gaps feed the block while a monitor with random stalls checks each
// result beat against a predictor holding its own line stores and window.
// Frames of several sizes, drains in and out of place, register extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import sem_pkg::*;
  import sem_tb_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 4096;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  sem_in_if  in_bus ();
  sem_out_if out_bus ();

  sobel_edge_magnitude_3x3 dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned fw, fh;
  logic [23:0] upper_line [MAXW];
  logic [23:0] middle_line [MAXW];
  logic [23:0] win [3][3];
  int unsigned in_col, in_row, out_col, out_row;

  pixel_beat_t pending_pixels[$];
  edge_beat_t  expected_edges[$];
  int failures = 0;

  function automatic int unsigned width_eff();
    if (fw < 1) return 1;
    if (fw > MAXW) return MAXW;
    return fw;
  endfunction

  function automatic int unsigned height_eff();
    if (fh < 1) return 1;
    if (fh > MAXH) return MAXH;
    return fh;
  endfunction

  function automatic void restart_frame();
    for (int k = 0; k < 3; k++)
      for (int l = 0; l < 3; l++) win[k][l] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned n;
    n = 0;
    while (n < 256 && (n + 1) * n < s) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  function automatic logic [7:0] magnitude(int sh, bit ok [3][3]);
    int gx, gy, v;
    int kx [3][3];
    int ky [3][3];
    kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
    gx = 0; gy = 0;
    for (int k = 0; k < 3; k++)
      for (int l = 0; l < 3; l++)
        if (ok[k][l]) begin
          v = (win[k][l] >> sh) & 8'hff;
          gx += v * kx[k][l];
          gy += v * ky[k][l];
        end
    return rounded_root(gx * gx + gy * gy);
  endfunction

  // Advance the predictor by one accepted beat
  function automatic void predict_edge(pixel_beat_t b);
    int unsigned w, h, r, c;
    bit drain_slot, emit, lst;
    logic [23:0] pix, up, mid;
    bit ok [3][3];
    edge_beat_t e;
    w = width_eff(); h = height_eff();
    drain_slot = in_row >= h;
    if (b.drain && !drain_slot) return;
    pix = drain_slot ? 24'h0 : {b.blue, b.green, b.red};
    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
    up = upper_line[in_col];
    mid = middle_line[in_col];
    upper_line[in_col] = mid;
    middle_line[in_col] = pix;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up; win[1][2] = mid; win[2][2] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    for (int k = 0; k < 3; k++) begin
      r = out_row + k;
      for (int l = 0; l < 3; l++) begin
        c = out_col + l;
        ok[k][l] = r >= 1 && r - 1 < h && c >= 1 && c - 1 < w;
      end
    end
    e.red = magnitude(0, ok);
    e.green = magnitude(8, ok);
    e.blue = magnitude(16, ok);
    lst = out_row + 1 >= h && out_col + 1 >= w;
    e.last = lst;
    expected_edges.push_back(e);
    if (lst) restart_frame();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic pixel_beat_t rand_pixel(bit drain);
    pixel_beat_t b;
    b.drain = drain;
    b.red = 8'($urandom); b.green = 8'($urandom); b.blue = 8'($urandom);
    return b;
  endfunction

  // Queue one whole frame of the current size with stray drains among its pixels and drain-slot beats at the end
  function automatic void queue_frame(int mode);
    int unsigned n;
    pixel_beat_t b;
    n = width_eff() * height_eff();
    for (int unsigned i = 0; i < n; i++) begin
      b = rand_pixel(1'b0);
      if (mode == 1) begin
        b.red = '1; b.green = '0; b.blue = (i % 2) ? 8'hff : 8'h00;
      end
      if ($urandom_range(0, 40) == 0) pending_pixels.push_back(rand_pixel(1'b1));
      pending_pixels.push_back(b);
    end
    for (int unsigned i = 0; i < width_eff() + 1; i++)
      pending_pixels.push_back(rand_pixel($urandom_range(0, 3) != 0));
  endfunction

  // Driver: one beat at a time with a random gap before each
  int gap = 0;
  bit pause_req = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.operation <= 1'b0;
      in_bus.in_red <= '0; in_bus.in_green <= '0; in_bus.in_blue <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_edge({in_bus.operation, in_bus.in_red, in_bus.in_green, in_bus.in_blue});
        void'(pending_pixels.pop_front());
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the beat
      end else if (gap > 0) begin
        gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_pixels.size() > 0 && !pause_req) begin
        in_bus.valid <= 1'b1;
        {in_bus.operation, in_bus.in_red, in_bus.in_green, in_bus.in_blue}
          <= pending_pixels[0];
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls, compare each result beat with the oldest expectation
  int stall = 0;
  edge_beat_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.out_red, out_bus.out_green, out_bus.out_blue,
               out_bus.last_of_frame};
        if (expected_edges.size() == 0) begin
          $display("%0t: unexpected result beat exp none got %h", $realtime, got);
          failures++;
        end else begin
          want = expected_edges.pop_front();
          if (got.red !== want.red)
            $display("%0t: red exp %0d got %0d", $realtime, want.red, got.red);
          if (got.green !== want.green)
            $display("%0t: green exp %0d got %0d", $realtime, want.green, got.green);
          if (got.blue !== want.blue)
            $display("%0t: blue exp %0d got %0d", $realtime, want.blue, got.blue);
          if (got.last !== want.last)
            $display("%0t: last exp %0d got %0d", $realtime, want.last, got.last);
          if (got !== want) failures++;
        end
        stall = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_bus.valid || expected_edges.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One register write, with cfg_we low again before anything else
  task automatic write_reg(sem_reg_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) fw = value & 12'h7ff;
    else fh = value & 16'h1fff;
    restart_frame();
    @(posedge clk);
  endtask

  task automatic run_frames(int unsigned w, int unsigned h, int count, int mode);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    for (int i = 0; i < count; i++) queue_frame(mode);
  endtask

  initial begin
    int done_items;
    fw = 640; fh = 480;
    for (int i = 0; i < MAXW; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: tiny frames, extremes, stray drains, pixels in drain slots
    run_frames(1, 1, 2, 1);
    run_frames(3, 2, 1, 1);
    pending_pixels.push_back(rand_pixel(1'b1));
    run_frames(0, 0, 1, 0);
    // oversized width: part of a row, abandoned by the next write
    run_frames(2048 - 1, 1, 0, 0);
    for (int i = 0; i < 30; i++) pending_pixels.push_back(rand_pixel(1'b0));
    run_frames(2, 8191, 0, 0);
    for (int i = 0; i < 12; i++) pending_pixels.push_back(rand_pixel(1'b0));
    repeat (20) @(posedge clk);
    // sender holds off until all results are in, then resumes
    pause_req = 1'b1;
    while (expected_edges.size() > 0) @(posedge clk);
    pause_req = 1'b0;
    run_frames(1, 4096, 0, 0);
    for (int i = 0; i < 6; i++) pending_pixels.push_back(rand_pixel(1'b0));
    // random frames
    done_items = 0;
    while (done_items < 1200) begin
      int unsigned w, h;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      run_frames(w, h, $urandom_range(1, 2), 0);
      done_items += pending_pixels.size();
    end
    wait_idle();
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
